// ----- rtl/los_pkg.sv -----
// Shared types, constants and CORDIC arctangent table for the line-of-sight
// path guidance block. No dependencies.
package los_pkg;

  localparam int MAX_WAYPOINTS = 256;
  localparam int WP_AW         = $clog2(MAX_WAYPOINTS);
  localparam int CORDIC_STEPS  = 16;
  localparam int CW            = 40;   // CORDIC x/y datapath width
  localparam int ZW            = 32;   // angle width, 2^-24 rad units

  localparam logic signed [ZW-1:0] ANG_PI      = 32'sd52707179;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 32'sd26353589;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 32'sd105414358;
  localparam logic signed [CW-1:0] GAIN_Q30    = 40'sd652032875;

  localparam logic [1:0] REG_END_INDEX     = 2'd0;
  localparam logic [1:0] REG_LOOKAHEAD     = 2'd1;
  localparam logic [1:0] REG_SWITCH_RADIUS = 2'd2;

  localparam logic signed [ZW-1:0] ATAN_TAB [0:23] = '{
    32'sd13176795, 32'sd7778716, 32'sd4110060, 32'sd2086331,
    32'sd1047214,  32'sd524117,  32'sd262123,  32'sd131069,
    32'sd65536,    32'sd32768,   32'sd16384,   32'sd8192,
    32'sd4096,     32'sd2048,    32'sd1024,    32'sd512,
    32'sd256,      32'sd128,     32'sd64,      32'sd32,
    32'sd16,       32'sd8,       32'sd4,       32'sd2
  };

  // Request to the shared CORDIC unit
  typedef struct packed {
    logic start;
    logic vec;    // 1: vectoring (atan2), 0: rotation (cos/sin)
  } cor_req_t;

endpackage

// ----- rtl/los_ram.sv -----
// Generic single-port-write RAM with registered read.
// No dependencies.
module los_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/los_cordic.sv -----
// Shared iterative CORDIC unit: rotation (cos/sin in Q30) and vectoring
// (atan2 in 2^-24 rad), one micro-rotation per cycle. Uses los_pkg.
module los_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  los_pkg::cor_req_t              req,
  input  logic signed [los_pkg::CW-1:0]  x_in,
  input  logic signed [los_pkg::CW-1:0]  y_in,
  input  logic signed [los_pkg::ZW-1:0]  z_in,
  output logic                           busy,
  output logic                           done,
  output logic signed [los_pkg::CW-1:0]  x_out,
  output logic signed [los_pkg::CW-1:0]  y_out,
  output logic signed [los_pkg::ZW-1:0]  z_out
);

  logic [4:0]                      step;
  logic                            vec;
  logic                            neg;
  logic signed [los_pkg::CW-1:0]   x;
  logic signed [los_pkg::CW-1:0]   y;
  logic signed [los_pkg::ZW-1:0]   z;
  logic signed [los_pkg::CW-1:0]   xs;
  logic signed [los_pkg::CW-1:0]   ys;
  logic                            dir;
  logic signed [los_pkg::ZW-1:0]   atan;

  // One micro-rotation
  always_comb begin
    xs   = x >>> step;
    ys   = y >>> step;
    dir  = vec ? (y > 0) : (z < 0);
    atan = los_pkg::ATAN_TAB[step];
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        vec  <= req.vec;
        step <= '0;
        if (req.vec) begin
          neg <= 1'b0;
          if (x_in == '0 && y_in == '0) begin
            z    <= '0;
            done <= 1'b1;
          end else begin
            busy <= 1'b1;
            if (x_in < 0) begin
              x <= -x_in;
              y <= -y_in;
              z <= (y_in >= 0) ? los_pkg::ANG_PI : -los_pkg::ANG_PI;
            end else begin
              x <= x_in;
              y <= y_in;
              z <= '0;
            end
          end
        end else begin
          busy <= 1'b1;
          x    <= los_pkg::GAIN_Q30;
          y    <= '0;
          if (z_in > los_pkg::ANG_HALF_PI) begin
            z   <= z_in - los_pkg::ANG_PI;
            neg <= 1'b1;
          end else if (z_in < -los_pkg::ANG_HALF_PI) begin
            z   <= z_in + los_pkg::ANG_PI;
            neg <= 1'b1;
          end else begin
            z   <= z_in;
            neg <= 1'b0;
          end
        end
      end else if (busy) begin
        if (dir) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan;
        end
        step <= step + 5'd1;
        if (step == 5'(los_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign x_out = neg ? -x : x;
  assign y_out = neg ? -y : y;
  assign z_out = z;

endmodule

// ----- rtl/los_path_guidance_core.sv -----
// Line-of-sight path guidance: top level with the step sequencer, one shared
// multiplier, waypoint RAM and the shared CORDIC unit.
// A load word is written to the waypoint RAM on acceptance. A guidance word
// takes up to five CORDIC passes, a check per waypoint taken and a last check.
// One word at a time.
// Reset (rst, synchronous): tracking index and path angle clear, registers
// take their defaults; waypoint RAM is not cleared and holds garbage.
module los_path_guidance_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: wp_index[7:0] wp_x[39:8] wp_y[71:40] pos_x[103:72] pos_y[135:104]
  //        vel_east[151:136] vel_north[167:152] heading[183:168]
  //        speed_target[199:184]
  input  logic [199:0] s_tdata,
  // tuser: op (0 load waypoint, 1 guidance step)
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: heading_error[15:0] speed_error[32:16] sway_error[48:33]
  //        cross_track[80:49] track_index[88:81], zero above
  output logic [95:0]  m_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  typedef enum logic [31:0] {
    S_IDLE    = 32'h0000_0001,
    S_YAW_GO  = 32'h0000_0002,
    S_YAW_WT  = 32'h0000_0004,
    S_MU1     = 32'h0000_0008,
    S_MU2     = 32'h0000_0010,
    S_MU3     = 32'h0000_0020,
    S_MU4     = 32'h0000_0040,
    S_MU5     = 32'h0000_0080,
    S_ADV_CHK = 32'h0000_0100,
    S_ADV_RD  = 32'h0000_0200,
    S_ADV_DAT = 32'h0000_0400,
    S_ADV_CMP = 32'h0000_0800,
    S_SQ2     = 32'h0000_1000,
    S_SQ3     = 32'h0000_2000,
    S_SQ4     = 32'h0000_4000,
    S_SEG_A   = 32'h0000_8000,
    S_SEG_B   = 32'h0001_0000,
    S_SEG_C   = 32'h0002_0000,
    S_SEG_D   = 32'h0004_0000,
    S_SEG_E   = 32'h0008_0000,
    S_SEG_WT  = 32'h0010_0000,
    S_BETA_GO = 32'h0020_0000,
    S_BETA_WT = 32'h0040_0000,
    S_PA_GO   = 32'h0080_0000,
    S_PA_WT   = 32'h0100_0000,
    S_CT1     = 32'h0200_0000,
    S_CT2     = 32'h0400_0000,
    S_CT3     = 32'h0800_0000,
    S_LOS_GO  = 32'h1000_0000,
    S_LOS_WT  = 32'h2000_0000,
    S_WRAP    = 32'h4000_0000,
    S_OUT     = 32'h8000_0000
  } state_t;

  state_t state;

  // Configuration
  logic [7:0]  end_index;
  logic [30:0] lookahead;
  logic [30:0] switch_radius;

  // Tracking state
  logic [7:0]         cur_wp;
  logic signed [15:0] path_angle;

  // Captured word
  logic signed [31:0] px, py;
  logic signed [15:0] vx, vy, yaw, tgt;

  // Working registers
  logic signed [31:0] cs, sn, cy, sy;
  logic signed [17:0] u, v;
  logic [32:0]        ax, ay;
  logic signed [31:0] w0x, w0y;
  logic signed [31:0] beta;
  logic signed [35:0] e;
  logic signed [31:0] err;
  logic signed [63:0] acc, prod;
  logic [los_pkg::WP_AW-1:0] rd_addr;

  // Shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  // RAM
  logic        ram_we;
  logic [63:0] ram_rdata;

  // CORDIC
  los_pkg::cor_req_t             cor_req;
  logic signed [los_pkg::CW-1:0] cor_x, cor_y, cor_xo, cor_yo;
  logic signed [los_pkg::ZW-1:0] cor_z, cor_zo;
  logic                          cor_busy, cor_done;

  // Derived values
  logic               accept;
  logic               out_load;
  logic signed [32:0] ddx, ddy, dxp, dyp;
  logic signed [63:0] u_sum, v_sum, ct_sum;
  logic signed [31:0] pa_q, err_next, herr_q;
  logic signed [18:0] spd_d;
  logic signed [18:0] sway_d;
  logic [16:0]        speed_sat;
  logic [15:0]        sway_sat;
  logic [31:0]        ct_sat;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign ram_we   = accept && !s_tuser;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  los_ram #(.WIDTH(64), .DEPTH(los_pkg::MAX_WAYPOINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (los_pkg::WP_AW'(s_tdata[7:0])),
    .wdata ({s_tdata[71:40], s_tdata[39:8]}),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  los_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .req   (cor_req),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .z_in  (cor_z),
    .busy  (cor_busy),
    .done  (cor_done),
    .x_out (cor_xo),
    .y_out (cor_yo),
    .z_out (cor_zo)
  );

  // Differences against the vessel position and the stored waypoint
  always_comb begin
    ddx = 33'(signed'(ram_rdata[31:0])) - 33'(px);
    ddy = 33'(signed'(ram_rdata[63:32])) - 33'(py);
    dxp = 33'(px) - 33'(w0x);
    dyp = 33'(py) - 33'(w0y);
  end

  // Select CORDIC request and operands
  always_comb begin
    cor_req.start = 1'b0;
    cor_req.vec   = 1'b0;
    cor_x         = '0;
    cor_y         = '0;
    cor_z         = '0;
    case (state)
      S_YAW_GO: begin
        cor_req.start = 1'b1;
        cor_z         = 32'(yaw) <<< 11;
      end
      S_SEG_E: begin
        cor_req.start = 1'b1;
        cor_req.vec   = 1'b1;
        cor_x = los_pkg::CW'(signed'(ram_rdata[31:0])) - los_pkg::CW'(w0x);
        cor_y = los_pkg::CW'(signed'(ram_rdata[63:32])) - los_pkg::CW'(w0y);
      end
      S_BETA_GO: begin
        cor_req.start = 1'b1;
        cor_req.vec   = 1'b1;
        cor_x         = los_pkg::CW'(u);
        cor_y         = los_pkg::CW'(v);
      end
      S_PA_GO: begin
        cor_req.start = 1'b1;
        cor_z         = 32'(path_angle) <<< 11;
      end
      S_LOS_GO: begin
        cor_req.start = 1'b1;
        cor_req.vec   = 1'b1;
        cor_x         = los_pkg::CW'({1'b0, lookahead});
        cor_y         = -los_pkg::CW'(e);
      end
      default: begin
        cor_req.start = 1'b0;
      end
    endcase
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MU1: begin
        mul_a = 34'(vx);
        mul_b = 34'(cs);
      end
      S_MU2: begin
        mul_a = 34'(vy);
        mul_b = 34'(sn);
      end
      S_MU3: begin
        mul_a = 34'(vy);
        mul_b = 34'(cs);
      end
      S_MU4: begin
        mul_a = 34'(vx);
        mul_b = 34'(sn);
      end
      S_ADV_CMP: begin
        mul_a = signed'({1'b0, ax});
        mul_b = signed'({1'b0, ax});
      end
      S_SQ2: begin
        mul_a = signed'({1'b0, ay});
        mul_b = signed'({1'b0, ay});
      end
      S_SQ3: begin
        mul_a = signed'({3'b000, switch_radius});
        mul_b = signed'({3'b000, switch_radius});
      end
      S_CT1: begin
        mul_a = 34'(dxp);
        mul_b = 34'(sy >>> 2);
      end
      S_CT2: begin
        mul_a = 34'(dyp);
        mul_b = 34'(cy >>> 2);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounding and saturation
  always_comb begin
    u_sum    = acc + prod + 64'sd536870912;
    v_sum    = acc - prod + 64'sd536870912;
    ct_sum   = prod - acc + 64'sd134217728;
    pa_q     = (cor_zo + 32'sd1024) >>> 11;
    err_next = (32'(path_angle) <<< 11) - beta + cor_zo - (32'(yaw) <<< 11);
    herr_q   = (err + 32'sd1024) >>> 11;
    spd_d    = 19'(tgt) - 19'(u);
    sway_d   = -19'(v);
    if (spd_d > 19'sd65535) begin
      speed_sat = 17'h0FFFF;
    end else if (spd_d < -19'sd65536) begin
      speed_sat = 17'h10000;
    end else begin
      speed_sat = spd_d[16:0];
    end
    if (sway_d > 19'sd32767) begin
      sway_sat = 16'h7FFF;
    end else if (sway_d < -19'sd32768) begin
      sway_sat = 16'h8000;
    end else begin
      sway_sat = sway_d[15:0];
    end
    if (e > 36'sd2147483647) begin
      ct_sat = 32'h7FFF_FFFF;
    end else if (e < -36'sd2147483648) begin
      ct_sat = 32'h8000_0000;
    end else begin
      ct_sat = e[31:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      end_index     <= 8'd0;
      lookahead     <= 31'd65536;
      switch_radius <= 31'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        los_pkg::REG_END_INDEX:     end_index     <= cfg_data[7:0];
        los_pkg::REG_LOOKAHEAD:     lookahead     <= cfg_data;
        los_pkg::REG_SWITCH_RADIUS: switch_radius <= cfg_data;
        default:                    end_index     <= end_index;
      endcase
    end
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_wp     <= 8'd0;
      path_angle <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // Drop valid once taken, unless a new result loads in the same cycle
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!s_tuser) begin
              if (s_tdata[7:0] == 8'd0) begin
                cur_wp <= 8'd0;
              end
            end else if (cur_wp < end_index) begin
              px    <= signed'(s_tdata[103:72]);
              py    <= signed'(s_tdata[135:104]);
              vx    <= signed'(s_tdata[151:136]);
              vy    <= signed'(s_tdata[167:152]);
              yaw   <= signed'(s_tdata[183:168]);
              tgt   <= signed'(s_tdata[199:184]);
              state <= S_YAW_GO;
            end
          end
        end
        S_YAW_GO: state <= S_YAW_WT;
        S_YAW_WT: begin
          if (cor_done) begin
            cs    <= cor_xo[31:0];
            sn    <= cor_yo[31:0];
            state <= S_MU1;
          end
        end
        // Body-frame velocity
        S_MU1: begin
          prod  <= mul_p[63:0];
          state <= S_MU2;
        end
        S_MU2: begin
          acc   <= prod;
          prod  <= mul_p[63:0];
          state <= S_MU3;
        end
        S_MU3: begin
          u     <= u_sum[47:30];
          prod  <= mul_p[63:0];
          state <= S_MU4;
        end
        S_MU4: begin
          acc   <= prod;
          prod  <= mul_p[63:0];
          state <= S_MU5;
        end
        S_MU5: begin
          v     <= v_sum[47:30];
          state <= S_ADV_CHK;
        end
        // Advance past waypoints inside the switch radius
        S_ADV_CHK: begin
          if (cur_wp < end_index) begin
            rd_addr <= los_pkg::WP_AW'(cur_wp);
            state   <= S_ADV_RD;
          end else begin
            state   <= S_SEG_A;
          end
        end
        S_ADV_RD: state <= S_ADV_DAT;
        S_ADV_DAT: begin
          ax    <= ddx[32] ? 33'(-ddx) : 33'(ddx);
          ay    <= ddy[32] ? 33'(-ddy) : 33'(ddy);
          state <= S_ADV_CMP;
        end
        S_ADV_CMP: begin
          if (ax > {2'b00, switch_radius} || ay > {2'b00, switch_radius}) begin
            state <= S_SEG_A;
          end else begin
            prod  <= mul_p[63:0];
            state <= S_SQ2;
          end
        end
        S_SQ2: begin
          acc   <= prod;
          prod  <= mul_p[63:0];
          state <= S_SQ3;
        end
        S_SQ3: begin
          acc   <= acc + prod;
          prod  <= mul_p[63:0];
          state <= S_SQ4;
        end
        S_SQ4: begin
          if (acc > prod) begin
            state  <= S_SEG_A;
          end else begin
            cur_wp <= cur_wp + 8'd1;
            state  <= S_ADV_CHK;
          end
        end
        // Segment angle
        S_SEG_A: begin
          rd_addr <= los_pkg::WP_AW'(cur_wp);
          state   <= S_SEG_B;
        end
        S_SEG_B: state <= S_SEG_C;
        S_SEG_C: begin
          w0x <= signed'(ram_rdata[31:0]);
          w0y <= signed'(ram_rdata[63:32]);
          if (cur_wp != end_index) begin
            rd_addr <= los_pkg::WP_AW'(cur_wp + 8'd1);
            state   <= S_SEG_D;
          end else begin
            state   <= S_BETA_GO;
          end
        end
        S_SEG_D: state <= S_SEG_E;
        S_SEG_E: state <= S_SEG_WT;
        S_SEG_WT: begin
          if (cor_done) begin
            if (pa_q > 32'sd32767) begin
              path_angle <= 16'sh7FFF;
            end else if (pa_q < -32'sd32768) begin
              path_angle <= 16'sh8000;
            end else begin
              path_angle <= pa_q[15:0];
            end
            state <= S_BETA_GO;
          end
        end
        // Drift angle
        S_BETA_GO: state <= S_BETA_WT;
        S_BETA_WT: begin
          if (cor_done) begin
            beta  <= cor_zo;
            state <= S_PA_GO;
          end
        end
        S_PA_GO: state <= S_PA_WT;
        S_PA_WT: begin
          if (cor_done) begin
            cy    <= cor_xo[31:0];
            sy    <= cor_yo[31:0];
            state <= S_CT1;
          end
        end
        // Cross-track error
        S_CT1: begin
          prod  <= mul_p[63:0];
          state <= S_CT2;
        end
        S_CT2: begin
          acc   <= prod;
          prod  <= mul_p[63:0];
          state <= S_CT3;
        end
        S_CT3: begin
          e     <= ct_sum[63:28];
          state <= S_LOS_GO;
        end
        // Line-of-sight heading and error
        S_LOS_GO: state <= S_LOS_WT;
        S_LOS_WT: begin
          if (cor_done) begin
            err   <= err_next;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (err > los_pkg::ANG_PI) begin
            err <= err - los_pkg::ANG_TWO_PI;
          end else if (err <= -los_pkg::ANG_PI) begin
            err <= err + los_pkg::ANG_TWO_PI;
          end else begin
            state <= S_OUT;
          end
        end
        // Hold until the output register frees
        S_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, cur_wp, ct_sat, sway_sat, speed_sat, herr_q[15:0]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // CORDIC is never restarted mid-run
  a_cor_start_idle: assert property (@(posedge clk) disable iff (rst)
    cor_req.start |-> !cor_busy)
    else $error("CORDIC started while busy");

  // Waypoint writes only from an accepted load word
  a_ram_we_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE) && !s_tuser)
    else $error("waypoint write outside idle");

  // A result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result overwrite");

  // A finished CORDIC pass leaves the unit idle
  a_cor_done: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> !cor_busy)
    else $error("CORDIC done while busy");
`endif

endmodule
